### hw/rtl/fgrc_pkg.sv
// Shared types and constants for the functional graph reach counter.
package fgrc_pkg;

  localparam int MAX_NODES = 1024;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = IDX_W + 1;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // command from the channel side to the engine
  typedef struct packed {
    logic             start;
    logic             mode;
    logic [IDX_W-1:0] node;
    logic [IDX_W-1:0] succ;
  } cmd_t;

  // engine status back to the channel side
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [CNT_W-1:0] count;
    logic             status;
  } rsp_t;

endpackage

### hw/rtl/fgrc_engine.sv
// Graph tables, analysis sequencer and query lookup.
module fgrc_engine (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [fgrc_pkg::CNT_W-1:0]  n_eff,
  input  logic                        cfg_wr,
  input  logic                        out_free,
  input  fgrc_pkg::cmd_t              cmd,
  output fgrc_pkg::rsp_t              rsp
);

  localparam int IW = fgrc_pkg::IDX_W;
  localparam int CW = fgrc_pkg::CNT_W;
  localparam int D  = fgrc_pkg::MAX_NODES;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_START = 4'd2;
  localparam logic [3:0] S_WRD   = 4'd3;
  localparam logic [3:0] S_WEV   = 4'd4;
  localparam logic [3:0] S_CRD   = 4'd5;
  localparam logic [3:0] S_CWR   = 4'd6;
  localparam logic [3:0] S_UNW   = 4'd7;
  localparam logic [3:0] S_UWR   = 4'd8;
  localparam logic [3:0] S_ARD   = 4'd9;
  localparam logic [3:0] S_ALD   = 4'd10;
  localparam logic [3:0] S_RESP  = 4'd11;

  logic [3:0]    state;
  logic          valid;
  logic [CW-1:0] s;
  logic [IW-1:0] v;
  logic [CW-1:0] top;
  logic [CW-1:0] base;
  logic [CW-1:0] k;
  logic [CW-1:0] len;
  logic [CW-1:0] carry;
  logic [IW-1:0] qnode;
  logic [CW-1:0] res_cnt;

  // memories
  logic [IW-1:0] succ_mem  [D];
  logic [CW-1:0] visit_mem [D];
  logic [IW-1:0] low_mem   [D];
  logic [CW-1:0] ans_mem   [D];
  logic [IW-1:0] stk_mem   [D];

  logic [IW-1:0] succ_q, low_q, stk_q;
  logic [CW-1:0] visit_q, ans_q;

  logic [CW-1:0] stamp;
  logic [CW-1:0] carry_inc;
  logic [CW-1:0] top_dec;
  logic [IW-1:0] ans_ra, stk_ra;
  logic          wr_ok;
  logic          succ_we, visit_we, push, ans_we;
  logic [IW-1:0] visit_wa, ans_wa;
  logic [CW-1:0] visit_wd, ans_wd;

  assign stamp     = s + CW'(1);
  assign carry_inc = (carry != '0) ? carry + CW'(1) : '0;
  assign top_dec   = top - CW'(1);
  assign wr_ok     = ({1'b0, cmd.node} < n_eff) && ({1'b0, cmd.succ} < n_eff);

  // read and write address selection
  always_comb begin
    ans_ra   = (state == S_ARD) ? qnode : v;
    stk_ra   = (state == S_CRD) ? k[IW-1:0] : top_dec[IW-1:0];
    succ_we  = (state == S_IDLE) && cmd.start && (cmd.mode == fgrc_pkg::MODE_WRITE) && wr_ok;
    push     = (state == S_WEV) && (visit_q == '0);
    visit_we = (state == S_CLR && s != n_eff) || push;
    visit_wa = (state == S_CLR) ? s[IW-1:0] : v;
    visit_wd = (state == S_CLR) ? '0 : stamp;
    ans_we   = (state == S_CWR) || (state == S_UWR);
    ans_wa   = stk_q;
    ans_wd   = (state == S_CWR) ? len : carry_inc;
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (succ_we) succ_mem[cmd.node] <= cmd.succ;
    succ_q <= succ_mem[v];
  end

  always_ff @(posedge clk) begin
    if (visit_we) visit_mem[visit_wa] <= visit_wd;
    visit_q <= visit_mem[v];
  end

  always_ff @(posedge clk) begin
    if (push) low_mem[v] <= top[IW-1:0];
    low_q <= low_mem[v];
  end

  always_ff @(posedge clk) begin
    if (push) stk_mem[top[IW-1:0]] <= v;
    stk_q <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (ans_we) ans_mem[ans_wa] <= ans_wd;
    ans_q <= ans_mem[ans_ra];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
    end else begin
      if (cfg_wr) valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd.start) begin
            if (cmd.mode == fgrc_pkg::MODE_WRITE) begin
              if (wr_ok) begin
                valid <= 1'b0;
              end else begin
                res_cnt <= '0;
                state   <= S_RESP;
              end
            end else if ({1'b0, cmd.node} >= n_eff) begin
              res_cnt <= '0;
              state   <= S_RESP;
            end else begin
              qnode <= cmd.node;
              s     <= '0;
              state <= valid ? S_ARD : S_CLR;
            end
          end
        end
        // clear visit stamps of all nodes in use
        S_CLR: begin
          if (s == n_eff) begin
            s     <= '0;
            state <= S_START;
          end else begin
            s <= s + CW'(1);
          end
        end
        S_START: begin
          if (s == n_eff) begin
            valid <= 1'b1;
            state <= S_ARD;
          end else begin
            v     <= s[IW-1:0];
            top   <= '0;
            state <= S_WRD;
          end
        end
        S_WRD: begin
          if ({1'b0, v} >= n_eff) begin
            carry <= '0;
            state <= S_UNW;
          end else begin
            state <= S_WEV;
          end
        end
        // new node, own cycle, or known answer
        S_WEV: begin
          if (visit_q == '0) begin
            top   <= top + CW'(1);
            v     <= succ_q;
            state <= S_WRD;
          end else if (visit_q == stamp) begin
            base  <= {1'b0, low_q};
            k     <= {1'b0, low_q};
            len   <= top - {1'b0, low_q};
            state <= S_CRD;
          end else begin
            carry <= ans_q;
            state <= S_UNW;
          end
        end
        S_CRD: state <= S_CWR;
        S_CWR: begin
          k <= k + CW'(1);
          if (k + CW'(1) == top) begin
            top   <= base;
            carry <= len;
            state <= S_UNW;
          end else begin
            state <= S_CRD;
          end
        end
        // pop tail nodes, each one longer than its successor
        S_UNW: begin
          if (top == '0) begin
            s     <= s + CW'(1);
            state <= S_START;
          end else begin
            top   <= top_dec;
            state <= S_UWR;
          end
        end
        S_UWR: begin
          carry <= carry_inc;
          state <= S_UNW;
        end
        S_ARD: state <= S_ALD;
        S_ALD: begin
          res_cnt <= ans_q;
          state   <= S_RESP;
        end
        S_RESP: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.busy   = (state != S_IDLE);
  assign rsp.done   = (state == S_RESP) && out_free;
  assign rsp.count  = res_cnt;
  assign rsp.status = (res_cnt == '0) ? fgrc_pkg::STATUS_ERR : fgrc_pkg::STATUS_OK;

endmodule

### hw/rtl/functional_graph_reach_count.sv
// Top level: channels, node_count register and result register.
//
//  channel | dir | handshake            | payload
//  in      | in  | in_valid / in_stall  | mode, node, successor
//  out     | out | out_valid / out_stall| reach_count, status
//  cfg     | in  | cfg_valid / cfg_ready| cfg_data (node_count)
//
// The first query after a stored successor write or a node_count change runs
// the analysis: stamp clearing for all n nodes in use, then per node a start
// check, push and resolve on the one-read one-write tables, n being the
// effective node count. Synchronous reset sets node_count to 1 and marks the
// analysis stale. in_stall is high while the sequencer is busy, and a
// result waits in the sequencer while out_stall holds the output word.
module functional_graph_reach_count (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           mode,
  input  logic [fgrc_pkg::IDX_W-1:0]     node,
  input  logic [fgrc_pkg::IDX_W-1:0]     successor,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fgrc_pkg::CNT_W-1:0]     reach_count,
  output logic                           status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fgrc_pkg::CNT_W-1:0]     cfg_data
);

  localparam int CW = fgrc_pkg::CNT_W;

  logic [CW-1:0]  node_count;
  logic [CW-1:0]  n_eff;
  logic           cfg_wr;
  logic           out_free;
  fgrc_pkg::cmd_t cmd;
  fgrc_pkg::rsp_t rsp;

  assign cfg_ready = !rsp.busy;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = rsp.busy;
  assign out_free  = !out_valid || !out_stall;
  assign n_eff     = (node_count > CW'(fgrc_pkg::MAX_NODES)) ?
                     CW'(fgrc_pkg::MAX_NODES) : node_count;

  assign cmd.start = in_valid && !in_stall;
  assign cmd.mode  = mode;
  assign cmd.node  = node;
  assign cmd.succ  = successor;

  // node_count register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CW'(1);
    end else if (cfg_wr) begin
      node_count <= cfg_data;
    end
  end

  fgrc_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .n_eff    (n_eff),
    .cfg_wr   (cfg_wr),
    .out_free (out_free),
    .cmd      (cmd),
    .rsp      (rsp)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.done) begin
      reach_count <= rsp.count;
      status      <= rsp.status;
    end
  end

`ifndef SYNTH
  a_status_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((status == fgrc_pkg::STATUS_ERR) == (reach_count == '0)))
    else $error("status disagrees with reach_count");

  a_word_from_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> rsp.busy)
    else $error("result word without active sequencer");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.start && cmd.mode == fgrc_pkg::MODE_QUERY) |=> rsp.busy)
    else $error("query accepted but sequencer idle");
`endif

endmodule
